[hw/rtl/fat12_pkg.sv]
// Shared types and constants for the FAT12 cluster chain engine.
`default_nettype none
package fat12_pkg;
    localparam int unsigned TableBytes = 6144;
    localparam int unsigned SearchLimit = 4086;

    localparam logic [2:0] KIND_LOAD  = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_GET   = 3'd2;
    localparam logic [2:0] KIND_SET   = 3'd3;
    localparam logic [2:0] KIND_ALLOC = 3'd4;
    localparam logic [2:0] KIND_FREE  = 3'd5;
    localparam logic [2:0] KIND_FIND  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [11:0] EocMark = 12'hFFF;
    localparam logic [11:0] EocMin  = 12'hFF8;

    // datapath commands from the controller
    typedef struct packed {
        logic        ld_item;    // capture input item
        logic        rd_lo;      // read byte at entry offset (or byte address)
        logic        rd_hi;      // read byte at entry offset + 1
        logic        wr_lo;      // write low byte of current entry
        logic        wr_hi;      // write high byte of current entry
        logic        wr_raw;     // load-kind byte write
        logic        ent_cur;    // 0: entry index = cur, 1: entry index = prev
        logic        wval_sel;   // 0: write EocMark, 1: write cur (link), 2 via zero
        logic        wval_zero;  // write zero
        logic        wval_item;  // write item's entry_value
        logic        cur_init2;  // cur <= 2
        logic        cur_inc;    // cur <= cur + 1
        logic        cur_from_ent; // cur <= entry value read
        logic        prev_ld;    // prev <= cur, first <= cur if count==0
        logic        cnt_inc;
        logic        cap_byte;   // capture byte_out from read data
        logic        cap_val;    // value <= assembled entry
        logic        cap_first;  // value <= first
        logic        cap_cur;    // value <= cur
        logic        set_full;
        logic        set_range;
    } fat12_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       addr_ok;     // byte address in range
        logic       ent_zero;    // assembled entry is zero
        logic       cur_end;     // cur >= SearchLimit
        logic       free_stop;   // cur < 2 or cur >= EocMin
        logic       cnt_done;    // count >= need
        logic       cnt_zero;
    } fat12_sts_t;
endpackage
`default_nettype wire

[hw/rtl/fat12_dp.sv]
// Datapath: table memory, entry packing, chain registers and result registers.
`default_nettype none
module fat12_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fat12_pkg::fat12_cmd_t cmd,
    output fat12_pkg::fat12_sts_t     sts,
    input  wire logic [1:0]           cluster_shift,
    input  wire logic [2:0]           in_kind,
    input  wire logic [12:0]          in_byte_address,
    input  wire logic [7:0]           in_byte_data,
    input  wire logic [11:0]          in_cluster,
    input  wire logic [11:0]          in_entry_value,
    input  wire logic [23:0]          in_size_bytes,
    input  wire logic                 clr_result,
    output logic [1:0]                status,
    output logic [11:0]               value,
    output logic [7:0]                byte_out,
    output logic [12:0]               cluster_count
);
    logic [7:0]  mem [fat12_pkg::TableBytes];
    logic [2:0]  kind_reg;
    logic [12:0] addr_reg;
    logic [7:0]  data_reg;
    logic [11:0] eval_reg;
    logic [12:0] need_reg;
    logic [11:0] cur_reg, prev_reg, first_reg;
    logic [12:0] cnt_reg;
    logic [7:0]  lo_reg, hi_reg;
    logic        lo_ok_reg, hi_ok_reg;
    logic [7:0]  rdata_reg;
    logic [1:0]  status_reg;
    logic [11:0] value_reg;
    logic [7:0]  bout_reg;

    // entry location
    logic [11:0] eidx;
    logic [13:0] eoff, eoff1;
    logic        eodd;
    logic [11:0] ent;
    logic [11:0] wval;
    logic [7:0]  wlo, whi;
    logic        lo_in, hi_in;
    logic [13:0] raddr;
    logic        rd_ok;
    logic [23:0] need_full;
    logic [24:0] sum;

    assign eidx  = cmd.ent_cur ? prev_reg : cur_reg;
    assign eodd  = eidx[0];
    assign eoff  = 14'(({2'b0, eidx} + {1'b0, eidx, 1'b0}) >> 1);
    assign eoff1 = eoff + 14'd1;
    assign lo_in = eoff < 14'(fat12_pkg::TableBytes);
    assign hi_in = eoff1 < 14'(fat12_pkg::TableBytes);
    assign ent = eodd ? {hi_reg, lo_reg[7:4]} : {hi_reg[3:0], lo_reg};

    always_comb begin
        if (cmd.wval_zero)      wval = 12'd0;
        else if (cmd.wval_item) wval = eval_reg;
        else if (cmd.wval_sel)  wval = cur_reg;
        else                    wval = fat12_pkg::EocMark;
    end
    assign wlo = eodd ? {wval[3:0], lo_reg[3:0]} : wval[7:0];
    assign whi = eodd ? wval[11:4] : {hi_reg[7:4], wval[11:8]};

    assign raddr = cmd.rd_hi ? eoff1 : (cmd.rd_lo ? eoff : {1'b0, addr_reg});
    assign rd_ok = raddr < 14'(fat12_pkg::TableBytes);

    // clusters needed = ceil(size / (512 << shift)), at least one
    assign sum = {1'b0, in_size_bytes} + ((25'd512 << cluster_shift) - 25'd1);
    assign need_full = 24'(sum >> (4'd9 + {2'b0, cluster_shift}));

    // table memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_raw && addr_reg < 13'(fat12_pkg::TableBytes)) begin
            mem[addr_reg] <= data_reg;
        end else if (cmd.wr_lo && lo_in) begin
            mem[eoff[12:0]] <= wlo;
        end else if (cmd.wr_hi && hi_in) begin
            mem[eoff1[12:0]] <= whi;
        end
        if (rd_ok) begin
            rdata_reg <= mem[raddr[12:0]];
        end
    end

    // byte latches: out-of-range bytes read as 0xFF
    always_ff @(posedge aclk) begin
        if (cmd.rd_lo || cmd.rd_hi) begin
            lo_ok_reg <= cmd.rd_lo ? rd_ok : lo_ok_reg;
            hi_ok_reg <= cmd.rd_hi ? rd_ok : hi_ok_reg;
        end
    end
    logic lo_pend_reg, hi_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_pend_reg <= 1'b0;
            hi_pend_reg <= 1'b0;
        end else begin
            lo_pend_reg <= cmd.rd_lo;
            hi_pend_reg <= cmd.rd_hi;
        end
        if (lo_pend_reg) lo_reg <= lo_ok_reg ? rdata_reg : 8'hFF;
        if (hi_pend_reg) hi_reg <= hi_ok_reg ? rdata_reg : 8'hFF;
    end

    // item and chain registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            kind_reg <= in_kind;
            addr_reg <= in_byte_address;
            data_reg <= in_byte_data;
            eval_reg <= in_entry_value;
            need_reg <= (need_full == 24'd0) ? 13'd1
                      : (need_full > 24'd4096) ? 13'd4096 : need_full[12:0];
            cnt_reg  <= '0;
            cur_reg  <= in_cluster;
            first_reg <= '0;
        end else begin
            if (cmd.cnt_inc) cnt_reg <= cnt_reg + 13'd1;
            if (cmd.cur_init2) cur_reg <= 12'd2;
            else if (cmd.cur_inc) cur_reg <= cur_reg + 12'd1;
            else if (cmd.cur_from_ent) cur_reg <= ent;
            if (cmd.prev_ld) begin
                prev_reg <= cur_reg;
                if (cnt_reg == 13'd0) first_reg <= cur_reg;
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (clr_result) begin
            status_reg <= fat12_pkg::ST_OK;
            value_reg  <= '0;
            bout_reg   <= '0;
        end else begin
            if (cmd.set_full)  status_reg <= fat12_pkg::ST_FULL;
            if (cmd.set_range) status_reg <= fat12_pkg::ST_RANGE;
            if (cmd.cap_byte)  bout_reg   <= rdata_reg;
            if (cmd.cap_val)   value_reg  <= ent;
            if (cmd.cap_first) value_reg  <= first_reg;
            if (cmd.cap_cur)   value_reg  <= cur_reg;
        end
    end

    assign status = status_reg;
    assign value = value_reg;
    assign byte_out = bout_reg;
    assign cluster_count = cnt_reg;

    assign sts.kind      = kind_reg;
    assign sts.addr_ok   = addr_reg < 13'(fat12_pkg::TableBytes);
    assign sts.ent_zero  = (ent == 12'd0);
    assign sts.cur_end   = cur_reg >= 12'(fat12_pkg::SearchLimit);
    assign sts.free_stop = (cur_reg < 12'd2) || (cur_reg >= fat12_pkg::EocMin);
    assign sts.cnt_done  = cnt_reg >= need_reg;
    assign sts.cnt_zero  = cnt_reg == 13'd0;
endmodule
`default_nettype wire

[hw/rtl/fat12_ctrl.sv]
// Controller state machine sequencing table accesses for each item kind.
`default_nettype none
module fat12_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_fire,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       clr_result,
    output fat12_pkg::fat12_cmd_t      cmd,
    input  wire fat12_pkg::fat12_sts_t sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RDLO  = 4'd2;  // issue low read
    localparam logic [3:0] S_RDHI  = 4'd3;  // issue high read
    localparam logic [3:0] S_WAIT1 = 4'd4;
    localparam logic [3:0] S_WAIT2 = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;  // entry assembled
    localparam logic [3:0] S_WRHI  = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;  // link prev to cur: read prev
    localparam logic [3:0] S_RAWRD = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_LWAIT = 4'd11;
    localparam logic [3:0] S_LWR   = 4'd12;
    localparam logic [3:0] S_LWRHI = 4'd13;
    localparam logic [3:0] S_ADV   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       link_reg, link_next;   // entry ops target prev

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            link_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            link_reg  <= link_next;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = (state_reg == S_DONE);
    assign clr_result = s_fire;

    always_comb begin
        state_next = state_reg;
        link_next  = link_reg;
        cmd        = '0;
        cmd.ent_cur = link_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cmd.ld_item = 1'b1;
                    link_next   = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.kind)
                    fat12_pkg::KIND_LOAD: begin
                        if (sts.addr_ok) cmd.wr_raw = 1'b1;
                        else cmd.set_range = 1'b1;
                        state_next = S_DONE;
                    end
                    fat12_pkg::KIND_READ: begin
                        if (sts.addr_ok) state_next = S_RAWRD;
                        else begin
                            cmd.set_range = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    fat12_pkg::KIND_GET, fat12_pkg::KIND_SET: state_next = S_RDLO;
                    fat12_pkg::KIND_ALLOC, fat12_pkg::KIND_FIND: begin
                        cmd.cur_init2 = 1'b1;
                        state_next = S_ADV;
                    end
                    fat12_pkg::KIND_FREE: state_next = S_ADV;
                    default: state_next = S_DONE;
                endcase
            end
            S_RAWRD: begin
                state_next = S_WAIT1;
            end
            S_ADV: begin
                // loop head for search and free walks
                if (sts.kind == fat12_pkg::KIND_FREE) begin
                    state_next = sts.free_stop ? S_DONE : S_RDLO;
                end else if (sts.kind == fat12_pkg::KIND_ALLOC && sts.cnt_done) begin
                    cmd.cap_first = 1'b1;
                    state_next = S_DONE;
                end else if (sts.cur_end) begin
                    cmd.set_full = 1'b1;
                    if (sts.kind == fat12_pkg::KIND_ALLOC) cmd.cap_first = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_RDLO;
                end
            end
            S_RDLO: begin
                cmd.rd_lo = 1'b1;
                state_next = S_RDHI;
            end
            S_RDHI: begin
                cmd.rd_hi = 1'b1;
                state_next = S_WAIT1;
            end
            S_WAIT1: begin
                if (sts.kind == fat12_pkg::KIND_READ) begin
                    cmd.cap_byte = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (sts.kind)
                    fat12_pkg::KIND_GET: begin
                        cmd.cap_val = 1'b1;
                        state_next = S_DONE;
                    end
                    fat12_pkg::KIND_SET: begin
                        cmd.wval_item = 1'b1;
                        cmd.wr_lo = 1'b1;
                        state_next = S_WRHI;
                    end
                    fat12_pkg::KIND_FIND: begin
                        if (sts.ent_zero) begin
                            cmd.cap_cur = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            cmd.cur_inc = 1'b1;
                            state_next = S_ADV;
                        end
                    end
                    fat12_pkg::KIND_ALLOC: begin
                        if (sts.ent_zero) begin
                            cmd.wr_lo = 1'b1;   // mark end of chain
                            state_next = S_WRHI;
                        end else begin
                            cmd.cur_inc = 1'b1;
                            state_next = S_ADV;
                        end
                    end
                    fat12_pkg::KIND_FREE: begin
                        cmd.wval_zero = 1'b1;
                        cmd.wr_lo = 1'b1;
                        state_next = S_WRHI;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_WRHI: begin
                cmd.wval_zero = (sts.kind == fat12_pkg::KIND_FREE);
                cmd.wval_item = (sts.kind == fat12_pkg::KIND_SET);
                cmd.wr_hi = 1'b1;
                unique case (sts.kind)
                    fat12_pkg::KIND_FREE: begin
                        cmd.cnt_inc = 1'b1;
                        cmd.cur_from_ent = 1'b1;
                        state_next = S_ADV;
                    end
                    fat12_pkg::KIND_ALLOC: begin
                        if (sts.cnt_zero) begin
                            cmd.prev_ld = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.cur_inc = 1'b1;
                            state_next = S_ADV;
                        end else begin
                            link_next = 1'b1;
                            state_next = S_LINK;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            // link previous cluster to the current one
            S_LINK: begin
                cmd.rd_lo = 1'b1;
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                cmd.rd_hi = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2: begin
                state_next = S_LWR;
            end
            S_LWR: begin
                cmd.wval_sel = 1'b1;
                cmd.wr_lo = 1'b1;
                state_next = S_LWRHI;
            end
            S_LWRHI: begin
                cmd.wval_sel = 1'b1;
                cmd.wr_hi = 1'b1;
                cmd.prev_ld = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.cur_inc = 1'b1;
                link_next = 1'b0;
                state_next = S_ADV;
            end
            S_DONE: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/fat12_cluster_chain_engine.sv]
// Top level of the FAT12 cluster chain engine.
// Usage:
//  - s_axis: one item per command; tuser = kind[2:0]; tdata (lowest bit up) =
//    byte_address[12:0], byte_data[7:0], cluster[11:0], entry_value[11:0],
//    size_bytes[23:0], zero pad to 72 bits.
//  - m_axis: one result per item; tdata = status[1:0], value[11:0],
//    byte_out[7:0], cluster_count[12:0], zero pad to 40 bits.
//  - cfg: cfg_valid/cfg_ready write of cluster_shift, only while idle.
// The single table memory port reads or writes one byte per cycle. Find
// scans entries one at a time; allocate scans entries and links each
// cluster it takes to the previous one; free clears each cluster in the
// chain in turn.
// One item is in work at a time; s_tready is high only when idle.
// The result is held on m_axis until m_tready; no new item is accepted
// until the result is taken. Reset clears control and cluster_shift; the
// table contents are undefined until loaded.
`default_nettype none
module fat12_cluster_chain_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // byte_address, byte_data, cluster, entry_value, size_bytes
    input  wire logic [2:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // status, value, byte_out, cluster_count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);
    fat12_pkg::fat12_cmd_t cmd;
    fat12_pkg::fat12_sts_t sts;
    logic [1:0]  shift_reg;
    logic        s_fire, clr;
    logic [1:0]  status;
    logic [11:0] value;
    logic [7:0]  byte_out;
    logic [12:0] cluster_count;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) shift_reg <= 2'd0;
        else if (cfg_valid) shift_reg <= cfg_data;
    end

    assign s_fire = s_axis_tvalid && s_axis_tready;

    fat12_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire, .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .clr_result(clr), .cmd, .sts
    );

    fat12_dp u_dp (
        .aclk, .aresetn, .cmd, .sts, .cluster_shift(shift_reg),
        .in_kind(s_axis_tuser),
        .in_byte_address(s_axis_tdata[12:0]),
        .in_byte_data(s_axis_tdata[20:13]),
        .in_cluster(s_axis_tdata[32:21]),
        .in_entry_value(s_axis_tdata[44:33]),
        .in_size_bytes(s_axis_tdata[68:45]),
        .clr_result(clr),
        .status, .value, .byte_out, .cluster_count
    );

    assign m_axis_tdata = {5'd0, cluster_count, byte_out, value, status};
endmodule
`default_nettype wire

[dv/fat12_chain_checker.sv]
// Watches the item, result and register channels, predicts each result and compares.
module fat12_chain_checker
    import fat12_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [12:0] count;
        logic [7:0]  byte_out;
        logic [11:0] value;
        logic [1:0]  status;
    } fat_result_t;

    fat_result_t result_q[$];
    logic [7:0]  fat_img[TableBytes];
    logic [1:0]  shift_r;

    function automatic logic [7:0] img_byte(int a);
        return (a < TableBytes) ? fat_img[a] : 8'hFF;
    endfunction

    function automatic void img_put(int a, logic [7:0] v);
        if (a < TableBytes) fat_img[a] = v;
    endfunction

    function automatic logic [11:0] entry_rd(int c);
        int off;
        logic [7:0] b0, b1;
        off = (c * 3) / 2;
        b0 = img_byte(off);
        b1 = img_byte(off + 1);
        return c[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
    endfunction

    function automatic void entry_wr(int c, logic [11:0] v);
        int off;
        logic [7:0] b;
        off = (c * 3) / 2;
        if (c[0]) begin
            b = img_byte(off);
            img_put(off, {v[3:0], b[3:0]});
            img_put(off + 1, v[11:4]);
        end else begin
            img_put(off, v[7:0]);
            b = img_byte(off + 1);
            img_put(off + 1, {b[7:4], v[11:8]});
        end
    endfunction

    // first-fit scan, 0 when nothing is free
    function automatic int first_free(int from);
        for (int c = from; c < SearchLimit; c++)
            if (entry_rd(c) == 12'd0) return c;
        return 0;
    endfunction

    function automatic fat_result_t predict(logic [2:0] kind, logic [71:0] d);
        fat_result_t r;
        int addr, clus, sh, need, prev, from, c, nxt;
        r = '0;
        addr = int'(d[12:0]);
        clus = int'(d[32:21]);
        case (kind)
            KIND_LOAD: begin
                if (addr < TableBytes) fat_img[addr] = d[20:13];
                else r.status = ST_RANGE;
            end
            KIND_READ: begin
                if (addr < TableBytes) r.byte_out = fat_img[addr];
                else r.status = ST_RANGE;
            end
            KIND_GET: r.value = entry_rd(clus);
            KIND_SET: entry_wr(clus, d[44:33]);
            KIND_ALLOC: begin
                sh = 9 + int'(shift_r);
                need = (int'(d[68:45]) + (1 << sh) - 1) >> sh;
                if (need == 0) need = 1;
                prev = 0;
                from = 2;
                while (r.count < need) begin
                    c = first_free(from);
                    if (c == 0) begin
                        r.status = ST_FULL;
                        break;
                    end
                    entry_wr(c, EocMark);
                    if (r.count == 0) r.value = 12'(c);
                    else entry_wr(prev, 12'(c));
                    prev = c;
                    from = c + 1;
                    r.count++;
                end
            end
            KIND_FREE: begin
                c = clus;
                while (c >= 2 && c < EocMin) begin
                    nxt = int'(entry_rd(c));
                    entry_wr(c, 12'd0);
                    r.count++;
                    c = nxt;
                end
            end
            KIND_FIND: begin
                r.value = 12'(first_free(2));
                if (r.value == 0) r.status = ST_FULL;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // sample every handshake at the rising edge
    always @(posedge aclk) begin
        fat_result_t want, got;
        if (!aresetn) begin
            shift_r <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) shift_r <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[34:0];
                if (result_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("%0t: st %0d/%0d val %h/%h byte %h/%h cnt %0d/%0d (exp/act)",
                                     $realtime, want.status, got.status, want.value,
                                     got.value, want.byte_out, got.byte_out,
                                     want.count, got.count);
                        fail_count++;
                    end
                end
            end
        end
        pending = result_q.size();
    end
endmodule

[dv/tb_top.sv]
// Stimulus, clock, reset and verdict for the FAT12 cluster chain engine.
module tb_top;
    import fat12_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_NONE = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;
    int          fail_count, pending;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_req = 1'b0;

    always #5 aclk = ~aclk;

    fat12_cluster_chain_engine dut (.*);
    fat12_chain_checker chk (.*);

    // full-table scans make single items long, so the limit is wide
    initial begin
        #1s;
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_axis_tready <= rx_steady || $urandom_range(99) >= 9;
        end
    end

    // offer one item; valid stays high on return, called at a falling edge
    task automatic send_item(logic [2:0] kind, logic [12:0] addr, logic [7:0] data,
                             logic [11:0] clus, logic [11:0] eval, logic [23:0] size);
        while (!tx_steady && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b0, size, eval, clus, data, addr};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_shift(logic [1:0] sh);
        s_axis_tvalid <= 1'b0;
        drain();
        repeat (10) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= sh;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // kind with the other fields as random noise
    task automatic send_kind(logic [2:0] kind, int arg, int arg2 = 0);
        logic [12:0] addr;
        logic [11:0] clus, eval;
        logic [23:0] size;
        addr = 13'($urandom);
        clus = 12'($urandom);
        eval = 12'($urandom);
        size = 24'($urandom);
        case (kind)
            KIND_LOAD, KIND_READ: addr = 13'(arg);
            KIND_GET, KIND_FREE: clus = 12'(arg);
            KIND_SET: begin
                clus = 12'(arg);
                eval = 12'(arg2);
            end
            KIND_ALLOC: size = 24'(arg);
            default: ;
        endcase
        send_item(kind, addr, (kind == KIND_LOAD) ? 8'(arg2) : 8'($urandom), clus, eval, size);
    endtask

    initial begin
        logic [7:0]  b;
        logic [12:0] a;
        int r, cb;
        logic [1:0] shifts[4] = '{2'd0, 2'd3, 2'd1, 2'd2};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill the whole table so no unwritten byte is ever read
        tx_steady = 1'b1;
        for (int i = 0; i < TableBytes; i++) begin
            if (i < 3) b = (i == 0) ? 8'hF0 : 8'hFF;
            else if (i < 96 || $urandom_range(99) >= 10) b = 8'h00;
            else b = 8'($urandom);
            send_item(KIND_LOAD, 13'(i), b, 12'($urandom), 12'($urandom), 24'($urandom));
        end
        tx_steady = 1'b0;

        // directed: extremes, range errors, cycles, disk full
        send_kind(KIND_READ, 0);
        send_kind(KIND_READ, TableBytes - 1);
        send_kind(KIND_READ, TableBytes);
        send_kind(KIND_LOAD, 8191, 8'hA5);
        send_kind(KIND_LOAD, TableBytes - 1, 8'h00);
        send_kind(KIND_GET, 0);
        send_kind(KIND_SET, 4095, 12'hFFF);
        send_kind(KIND_GET, 4095);
        send_kind(KIND_SET, 10, 11);
        send_kind(KIND_SET, 11, 10);
        send_kind(KIND_FREE, 10);
        send_kind(KIND_ALLOC, 0);
        send_kind(KIND_ALLOC, 1);
        send_kind(KIND_ALLOC, 1025);
        send_kind(KIND_FREE, 4);
        send_kind(KIND_FREE, 2);
        send_kind(KIND_FREE, 3);
        send_kind(KIND_FREE, 0);
        send_kind(KIND_FREE, 1);
        send_kind(KIND_FREE, 12'hFF8);
        send_kind(KIND_NONE, 0);
        send_kind(KIND_ALLOC, 24'hFFFFFF);
        send_kind(KIND_FIND, 0);
        send_kind(KIND_FREE, 2);
        send_kind(KIND_FIND, 0);

        // random phases, one cluster size each
        for (int ph = 0; ph < 4; ph++) begin
            write_shift(shifts[ph]);
            cb = 512 << shifts[ph];
            for (int i = 0; i < 100; i++) begin
                tx_steady = (ph == 1 && i < 60);
                rx_steady = (ph == 1 && i >= 20 && i < 80);
                if (ph == 2 && i == 50) hold_req = 1'b1;
                r = int'($urandom_range(99));
                a = ($urandom_range(9) == 0) ? 13'($urandom_range(8191, TableBytes))
                                             : 13'($urandom_range(TableBytes - 1));
                if (r < 12) send_kind(KIND_LOAD, int'(a), int'($urandom_range(255)));
                else if (r < 22) send_kind(KIND_READ, int'(a));
                else if (r < 37) send_kind(KIND_GET, int'($urandom_range(4095)));
                else if (r < 50)
                    send_kind(KIND_SET, int'($urandom_range(4095)),
                              $urandom_range(1) ? 0 : int'($urandom_range(4095)));
                else if (r < 68)
                    send_kind(KIND_ALLOC, ($urandom_range(99) == 0)
                                          ? int'($urandom_range(24'hFFFFFF))
                                          : int'($urandom_range(4 * cb)));
                else if (r < 85)
                    send_kind(KIND_FREE, $urandom_range(9) < 7 ? int'($urandom_range(40))
                                                               : int'($urandom_range(4095)));
                else if (r < 95) send_kind(KIND_FIND, 0);
                else send_kind(KIND_NONE, 0);
            end
        end
        rx_steady = 1'b0;
        tx_steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
